### rtl/i2a_pkg.sv
// ============================================================================
// i2a_pkg
// Shared types, codes and character constants of the integer to ascii
// formatter.
// ============================================================================
package i2a_pkg;

    localparam int BIN_W    = 32;
    localparam int NUM_DIG  = 10;
    localparam int POS_W    = 4;
    localparam int CNT_W    = 5;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [2:0] {
        FUNC_UDEC = 3'd0,
        FUNC_SDEC = 3'd1,
        FUNC_HEX  = 3'd2,
        FUNC_FIX2 = 3'd3,
        FUNC_FIX3 = 3'd4,
        FUNC_CRLF = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        SEL_DIGIT = 3'd0,
        SEL_MINUS = 3'd1,
        SEL_DOT   = 3'd2,
        SEL_CR    = 3'd3,
        SEL_LF    = 3'd4
    } t_char_sel;

    typedef struct packed {
        logic      load;
        logic      conv_step;
        logic      pos_load;
        logic      pos_dec;
        logic      emit;
        logic      last;
        t_char_sel sel;
    } t_cmd;

    typedef struct packed {
        logic [2:0] in_func;
        logic       neg;
        logic       conv_done;
        logic       pos_zero;
        logic       at_dot;
        logic       out_free;
    } t_sts;

    // digit value to ascii, decimal and uppercase hex alike
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] v;
        v = {4'd0, d};
        if (d < 4'd10) begin
            digit_char = CH_ZERO + v;
        end else begin
            digit_char = CH_A + v - 8'd10;
        end
    endfunction

endpackage

### rtl/i2a_dp.sv
// ============================================================================
// i2a_dp
// Datapath: operand registers, shift-add-3 binary to bcd converter, digit
// pointer and the output character register.
// ============================================================================
module i2a_dp import i2a_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_value,
    input  logic        i_stall,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic        o_valid,
    output logic [7:0]  o_ascii_char,
    output logic        o_last
);

    logic [BIN_W-1:0]              r_bin, n_bin;
    logic [NUM_DIG-1:0][3:0]       r_bcd, n_bcd;
    logic [NUM_DIG-1:0][3:0]       w_adj;
    logic [NUM_DIG*4-1:0]          w_adj_flat;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [POS_W-1:0]              r_pos, n_pos;
    logic [1:0]                    r_scale, n_scale;
    logic                          r_neg, n_neg;
    logic                          r_out_valid, n_out_valid;
    logic [7:0]                    r_out_char, n_out_char;
    logic                          r_out_last, n_out_last;

    logic                          w_signed;
    logic                          w_in_neg;
    logic [BIN_W-1:0]              w_mag;
    logic [POS_W-1:0]              w_msd;
    logic [POS_W-1:0]              w_start;
    logic [1:0]                    w_scale;
    logic                          w_out_free;

    always_comb begin
        w_signed = i_func inside {FUNC_SDEC, FUNC_FIX2, FUNC_FIX3};
        w_in_neg = w_signed && i_value[BIN_W-1];
        w_mag    = w_in_neg ? (~i_value + 32'd1) : i_value;
        case (t_func'(i_func))
            FUNC_FIX2: w_scale = 2'd2;
            FUNC_FIX3: w_scale = 2'd3;
            default:   w_scale = 2'd0;
        endcase
    end

    // add 3 to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIG; i++) begin
            w_adj[i] = (r_bcd[i] >= 4'd5) ? (r_bcd[i] + 4'd3) : r_bcd[i];
        end
        w_adj_flat = w_adj;
    end

    // highest nonzero digit, zero when all digits are zero
    always_comb begin
        w_msd = '0;
        for (int i = 0; i < NUM_DIG; i++) begin
            if (r_bcd[i] != 4'd0) begin
                w_msd = POS_W'(i);
            end
        end
        w_start = (w_msd < {2'b00, r_scale}) ? {2'b00, r_scale} : w_msd;
    end

    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_scale     = r_scale;
        n_neg       = r_neg;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && i_stall;

        if (i_cmd.load) begin
            n_bin   = w_mag;
            n_cnt   = '0;
            n_neg   = w_in_neg;
            n_scale = w_scale;
            n_bcd   = (i_func == FUNC_HEX) ? {8'd0, i_value} : '0;
        end
        if (i_cmd.conv_step) begin
            n_bcd = {w_adj_flat[NUM_DIG*4-2:0], r_bin[BIN_W-1]};
            n_bin = {r_bin[BIN_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
        end
        if (i_cmd.pos_load) begin
            n_pos = w_start;
        end
        if (i_cmd.pos_dec) begin
            n_pos = r_pos - 1'b1;
        end
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_out_last  = i_cmd.last;
            case (i_cmd.sel)
                SEL_DIGIT: n_out_char = digit_char(r_bcd[r_pos]);
                SEL_MINUS: n_out_char = CH_MINUS;
                SEL_DOT:   n_out_char = CH_DOT;
                SEL_CR:    n_out_char = CH_CR;
                SEL_LF:    n_out_char = CH_LF;
                default:   n_out_char = CH_ZERO;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_cnt      <= n_cnt;
        r_pos      <= n_pos;
        r_scale    <= n_scale;
        r_neg      <= n_neg;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    always_comb begin
        o_sts.in_func   = i_func;
        o_sts.neg       = r_neg;
        o_sts.conv_done = (r_cnt == CNT_W'(BIN_W - 1));
        o_sts.pos_zero  = (r_pos == '0);
        o_sts.at_dot    = (r_scale != 2'd0) && (r_pos == {2'b00, r_scale});
        o_sts.out_free  = w_out_free;
    end

    assign o_valid      = r_out_valid;
    assign o_ascii_char = r_out_char;
    assign o_last       = r_out_last;

endmodule

### rtl/i2a_ctrl.sv
// ============================================================================
// i2a_ctrl
// Controller: sequences load, conversion and character emission.
// ============================================================================
module i2a_ctrl import i2a_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CONV  = 8'b0000_0010,
        S_PREP  = 8'b0000_0100,
        S_SIGN  = 8'b0000_1000,
        S_DIGIT = 8'b0001_0000,
        S_DOT   = 8'b0010_0000,
        S_CR    = 8'b0100_0000,
        S_LF    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '{load: 1'b0, conv_step: 1'b0, pos_load: 1'b0, pos_dec: 1'b0,
                    emit: 1'b0, last: 1'b0, sel: SEL_DIGIT};
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    case (t_func'(i_sts.in_func))
                        FUNC_UDEC, FUNC_SDEC, FUNC_FIX2, FUNC_FIX3: n_state = S_CONV;
                        FUNC_HEX:  n_state = S_PREP;
                        FUNC_CRLF: n_state = S_CR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_CONV: begin
                o_cmd.conv_step = 1'b1;
                if (i_sts.conv_done) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.pos_load = 1'b1;
                n_state = i_sts.neg ? S_SIGN : S_DIGIT;
            end
            S_SIGN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_MINUS;
                    n_state    = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.sel     = SEL_DIGIT;
                    o_cmd.last    = i_sts.pos_zero;
                    o_cmd.pos_dec = !i_sts.pos_zero;
                    if (i_sts.pos_zero) begin
                        n_state = S_IDLE;
                    end else if (i_sts.at_dot) begin
                        n_state = S_DOT;
                    end
                end
            end
            S_DOT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_DOT;
                    n_state    = S_DIGIT;
                end
            end
            S_CR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_CR;
                    n_state    = S_LF;
                end
            end
            S_LF: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_LF;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

`ifndef NO_ASSERTIONS
    // a character is only written when the output register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("character written over a held beat");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_cmd.emit && !o_cmd.conv_step)
        else $error("activity while idle");

    a_conv_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV && i_sts.conv_done) |=> (r_state == S_PREP))
        else $error("conversion did not end in prep");

    a_last_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> (r_state == S_IDLE))
        else $error("last beat did not return to idle");
`endif

endmodule

### rtl/integer_to_ascii_formatter.sv
// ============================================================================
// integer_to_ascii_formatter
// Prints a 32-bit value as ascii text, one character per output beat.
// ============================================================================
// usage:
//   input channel  i_valid / o_stall carries i_func and i_value; one beat per
//   item. output channel o_valid / i_stall carries o_ascii_char and o_last,
//   with o_last high on the final character of the item.
//   decimal and fixed point modes run a shift-add-3 converter, one input bit
//   per cycle, then a setup state (S_PREP); hex skips the converter.
//   after that one character enters the output register per cycle while the
//   receiver does not stall, up to 12 characters for a decimal item. unused
//   modes are accepted but print nothing.
//   the next item is accepted once the last character sits in the output
//   register, so it may still be waiting there. a stall on the output holds
//   the register and pauses emission; conversion continues meanwhile.
//   reset clears the controller and the output valid; an item in progress
//   is dropped and its remaining characters are not printed.
// ============================================================================
module integer_to_ascii_formatter import i2a_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_ascii_char,
    output logic        o_last
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_busy;

    i2a_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy)
    );

    i2a_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_func       (i_func),
        .i_value      (i_value),
        .i_stall      (i_stall),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_valid      (o_valid),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last)
    );

    assign o_stall = w_busy;

endmodule
